[rtl/icr_pkg.sv]
`default_nettype none

package icr_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int FIELD_W = 48;
  localparam int DEPTH_W = 16;
  localparam int IMASS_W = 16;
  localparam int DEN_W = IMASS_W + 1;
  localparam int REST_W = 9;
  localparam int ONE_Q = 256;

  typedef enum logic [1:0] {
    KIND_ABSENT  = 2'd0,
    KIND_STATIC  = 2'd1,
    KIND_DYNAMIC = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CASE_NONE = 2'd0,
    CASE_BOTH = 2'd1,
    CASE_A    = 2'd2,
    CASE_B    = 2'd3
  } case_e;

  typedef struct packed {
    case_e code;
    logic  kneg;
    logic  kzero;
    logic  sat;
    logic  den_zero;
  } flags_t;

endpackage

`default_nettype wire

[rtl/icr_div.sv]
`default_nettype none

module icr_div #(
  parameter int DW = 32,
  parameter int VW = 17,
  parameter int QW = 24,
  parameter int SW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QW-1:0]      quot_o,
  output logic [SW-1:0]      side_o
);

  localparam int RW = (DW > VW + QW) ? DW : VW + QW;

  logic [RW-1:0] rem_q   [QW];
  logic [QW-1:0] quo_q   [QW];
  logic [VW-1:0] dvs_q   [QW];
  logic [SW-1:0] side_q  [QW];
  logic          valid_q [QW];

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d;
    logic [QW-1:0] quo_in;
    logic [VW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic          vin;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(dividend_i);
      assign quo_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
      assign vin     = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
      assign vin     = valid_q[s-1];
    end

    assign trial = RW'(dvs_in) << (QW - 1 - s);
    assign ge    = rem_in >= trial;
    assign rem_d = ge ? rem_in - trial : rem_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= {quo_in[QW-2:0], ge};
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

[rtl/icr_front.sv]
`default_nettype none

module icr_front #(
  parameter int W = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [icr_pkg::FIELD_W-1:0]  velocity_a_i,
  input  wire logic [icr_pkg::FIELD_W-1:0]  velocity_b_i,
  input  wire logic [icr_pkg::FIELD_W-1:0]  contact_normal_i,
  input  wire logic [icr_pkg::DEPTH_W-1:0]  penetration_depth_i,
  input  wire logic [icr_pkg::IMASS_W-1:0]  inv_mass_a_i,
  input  wire logic [icr_pkg::IMASS_W-1:0]  inv_mass_b_i,
  input  wire logic [icr_pkg::REST_W-1:0]   restitution_a_i,
  input  wire logic [icr_pkg::REST_W-1:0]   restitution_b_i,
  input  wire logic [1:0]                   kind_a_i,
  input  wire logic [1:0]                   kind_b_i,
  output logic                              valid_o,
  output icr_pkg::flags_t                   flags_o,
  output logic [2*W+14:0]                   kmag_o,
  output logic [icr_pkg::DEN_W-1:0]         den_o,
  output logic [3*(W+1)-1:0]                n_o,
  output logic [2*icr_pkg::DEPTH_W-1:0]     num_o,
  output logic [icr_pkg::DEPTH_W-1:0]       depth_o
);

  import icr_pkg::*;

  localparam int PADW = (3 * W > FIELD_W) ? 3 * W : FIELD_W;
  localparam int PW   = 2 * W + 2;
  localparam int DOTW = 2 * W + 4;
  localparam int KW   = DOTW + 11;
  localparam int LIMW = DEN_W + W + 16;
  localparam int CMPW = (KW > LIMW) ? KW : LIMW;
  localparam logic [W+15:0] JLIM = {1'b1, {(W + 14){1'b0}}, 1'b1};

  logic [PADW-1:0] va_pad, vb_pad, n_pad;
  assign va_pad = PADW'(velocity_a_i);
  assign vb_pad = PADW'(velocity_b_i);
  assign n_pad  = PADW'(contact_normal_i);

  logic dyn_a, dyn_b;
  assign dyn_a = kind_a_i == KIND_DYNAMIC;
  assign dyn_b = kind_b_i == KIND_DYNAMIC;

  case_e             code_d;
  logic [REST_W-1:0] ra_s, rb_s, e_d;
  logic [DEN_W-1:0]  den_d;
  logic signed [W:0] va_c [3];
  logic signed [W:0] vb_c [3];
  logic signed [W:0] n_c  [3];
  logic signed [W:0] u_d  [3];
  logic signed [W:0] n_d  [3];

  always_comb begin
    if (dyn_a && dyn_b) begin
      code_d = CASE_BOTH;
    end else if (dyn_a) begin
      code_d = CASE_A;
    end else if (dyn_b) begin
      code_d = CASE_B;
    end else begin
      code_d = CASE_NONE;
    end
    ra_s = (restitution_a_i > REST_W'(ONE_Q)) ? REST_W'(ONE_Q) : restitution_a_i;
    rb_s = (restitution_b_i > REST_W'(ONE_Q)) ? REST_W'(ONE_Q) : restitution_b_i;
    for (int i = 0; i < 3; i++) begin
      va_c[i] = $signed({va_pad[i*W+W-1], va_pad[i*W +: W]});
      vb_c[i] = $signed({vb_pad[i*W+W-1], vb_pad[i*W +: W]});
      n_c[i]  = $signed({n_pad[i*W+W-1], n_pad[i*W +: W]});
    end
    case (code_d)
      CASE_BOTH: begin
        for (int i = 0; i < 3; i++) begin
          u_d[i] = va_c[i] - vb_c[i];
          n_d[i] = n_c[i];
        end
        e_d   = (ra_s < rb_s) ? ra_s : rb_s;
        den_d = {1'b0, inv_mass_a_i} + {1'b0, inv_mass_b_i};
      end
      CASE_A: begin
        for (int i = 0; i < 3; i++) begin
          u_d[i] = va_c[i];
          n_d[i] = n_c[i];
        end
        e_d   = ra_s;
        den_d = {1'b0, inv_mass_a_i};
      end
      CASE_B: begin
        for (int i = 0; i < 3; i++) begin
          u_d[i] = vb_c[i];
          n_d[i] = -n_c[i];
        end
        e_d   = rb_s;
        den_d = {1'b0, inv_mass_b_i};
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          u_d[i] = '0;
          n_d[i] = '0;
        end
        e_d   = '0;
        den_d = '0;
      end
    endcase
  end

  // stage 0: decoded contact
  logic              v0_q, v1_q, v2_q, v3_q, v4_q;
  case_e             c0_q, c1_q, c2_q, c3_q;
  logic signed [W:0] u0_q [3];
  logic signed [W:0] n0_q [3];
  logic signed [W:0] n1_q [3];
  logic signed [W:0] n2_q [3];
  logic signed [W:0] n3_q [3];
  logic signed [W:0] n4_q [3];
  logic [REST_W-1:0] e0_q, e1_q, e2_q;
  logic [DEN_W-1:0]  den0_q, den1_q, den2_q, den3_q, den4_q;
  logic [IMASS_W-1:0] imb0_q, imb1_q;
  logic [DEPTH_W-1:0] dep0_q, dep1_q, dep2_q, dep3_q, dep4_q;
  logic signed [PW-1:0]   p1_q [3];
  logic signed [DOTW-1:0] dot2_q;
  logic [2*DEPTH_W-1:0]   num2_q, num3_q, num4_q;
  logic [LIMW-1:0]        lim2_q, lim3_q;
  logic signed [KW-1:0]   k3_q;
  logic [KW-1:0]          kmag4_q;
  flags_t                 f4_q;

  logic [9:0]    ec;
  logic [KW-1:0] kmag_d;
  assign ec     = 10'(ONE_Q) + {1'b0, e2_q};
  assign kmag_d = k3_q[KW-1] ? KW'(-k3_q) : KW'(k3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q   <= code_d;
      e0_q   <= e_d;
      den0_q <= den_d;
      imb0_q <= inv_mass_b_i;
      dep0_q <= penetration_depth_i;
      for (int i = 0; i < 3; i++) begin
        u0_q[i] <= u_d[i];
        n0_q[i] <= n_d[i];
      end
      // stage 1: component products
      c1_q   <= c0_q;
      e1_q   <= e0_q;
      den1_q <= den0_q;
      imb1_q <= imb0_q;
      dep1_q <= dep0_q;
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= PW'(u0_q[i] * n0_q[i]);
        n1_q[i] <= n0_q[i];
      end
      // stage 2: dot sum, depth share numerator, saturation limit
      c2_q   <= c1_q;
      e2_q   <= e1_q;
      den2_q <= den1_q;
      dep2_q <= dep1_q;
      dot2_q <= DOTW'(p1_q[0]) + DOTW'(p1_q[1]) + DOTW'(p1_q[2]);
      num2_q <= dep1_q * imb1_q;
      lim2_q <= den1_q * JLIM;
      for (int i = 0; i < 3; i++) n2_q[i] <= n1_q[i];
      // stage 3: k = dot * (1 + e)
      c3_q   <= c2_q;
      den3_q <= den2_q;
      dep3_q <= dep2_q;
      num3_q <= num2_q;
      lim3_q <= lim2_q;
      k3_q   <= KW'(dot2_q * $signed({1'b0, ec}));
      for (int i = 0; i < 3; i++) n3_q[i] <= n2_q[i];
      // stage 4: magnitude and range check
      f4_q.code     <= c3_q;
      f4_q.kneg     <= k3_q[KW-1];
      f4_q.kzero    <= k3_q == '0;
      f4_q.sat      <= CMPW'(kmag_d) >= CMPW'(lim3_q);
      f4_q.den_zero <= den3_q == '0;
      kmag4_q <= kmag_d;
      den4_q  <= den3_q;
      dep4_q  <= dep3_q;
      num4_q  <= num3_q;
      for (int i = 0; i < 3; i++) n4_q[i] <= n3_q[i];
    end
  end

  assign valid_o = v4_q;
  assign flags_o = f4_q;
  assign kmag_o  = kmag4_q;
  assign den_o   = den4_q;
  assign num_o   = num4_q;
  assign depth_o = dep4_q;
  assign n_o     = {n4_q[2], n4_q[1], n4_q[0]};

endmodule

`default_nettype wire

[rtl/icr_back.sv]
`default_nettype none

module icr_back #(
  parameter int W = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [W+15:0]               quot_j_i,
  input  wire logic [W+15:0]               quot_s_i,
  input  wire logic [3*(W+1)-1:0]          n_i,
  input  wire icr_pkg::flags_t             flags_i,
  input  wire logic [icr_pkg::DEPTH_W-1:0] depth_i,
  output logic                             valid_o,
  output logic [icr_pkg::FIELD_W-1:0]      impulse_a_o,
  output logic [icr_pkg::FIELD_W-1:0]      impulse_b_o,
  output logic [icr_pkg::FIELD_W-1:0]      shift_a_o,
  output logic [icr_pkg::FIELD_W-1:0]      shift_b_o,
  output logic [1:0]                       case_code_o
);

  import icr_pkg::*;

  localparam int JQ   = W + 16;
  localparam int TW   = 2 * W + 18;
  localparam int SHW  = W + 18;
  localparam int PADW = (3 * W > FIELD_W) ? 3 * W : FIELD_W;
  localparam logic [JQ-1:0] JMAX = {1'b1, {(W + 15){1'b0}}};

  function automatic logic signed [TW-1:0] tdiv(input logic signed [TW-1:0] x, input int sh);
    logic signed [TW-1:0] bias;
    bias = x[TW-1] ? $signed((TW'(1) << sh) - TW'(1)) : '0;
    return (x + bias) >>> sh;
  endfunction

  function automatic logic [W-1:0] sat(input logic signed [TW-1:0] x);
    if ((&x[TW-1:W-1]) || !(|x[TW-1:W-1])) begin
      return x[W-1:0];
    end
    return x[TW-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
  endfunction

  // stage B1: impulse scalar and depth split
  logic [JQ-1:0]       jmag;
  logic [DEPTH_W-1:0]  share, main_d;
  assign jmag   = flags_i.kzero ? '0 : (flags_i.sat ? JMAX : quot_j_i);
  assign share  = flags_i.den_zero ? {1'b0, depth_i[DEPTH_W-1:1]} : quot_s_i[DEPTH_W-1:0];
  assign main_d = (flags_i.code == CASE_BOTH) ? share : depth_i;

  logic                 v1_q, v2_q, v3_q;
  flags_t               f1_q, f2_q;
  logic signed [JQ:0]   j1_q;
  logic [DEPTH_W-1:0]   main1_q, other1_q;
  logic [3*(W+1)-1:0]   n1_q;
  logic signed [W:0]    n1c [3];
  logic signed [TW-1:0]  t2_q  [3];
  logic signed [SHW-1:0] sa2_q [3];
  logic signed [SHW-1:0] sb2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) n1c[i] = $signed(n1_q[i*(W+1) +: W+1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q     <= flags_i;
      j1_q     <= flags_i.kneg ? $signed({1'b0, jmag}) : -$signed({1'b0, jmag});
      main1_q  <= main_d;
      other1_q <= depth_i - main_d;
      n1_q     <= n_i;
      // stage B2: scale the normal
      f2_q <= f1_q;
      for (int i = 0; i < 3; i++) begin
        t2_q[i]  <= TW'(j1_q * n1c[i]);
        sa2_q[i] <= SHW'(n1c[i] * $signed({1'b0, main1_q}));
        sb2_q[i] <= SHW'(n1c[i] * $signed({1'b0, other1_q}));
      end
    end
  end

  // stage B3: truncate, saturate, select per case
  logic [W-1:0]   ti [3];
  logic [W-1:0]   ia_c [3];
  logic [W-1:0]   ib_c [3];
  logic [W-1:0]   sa_c [3];
  logic [W-1:0]   sb_c [3];
  logic [3*W-1:0] ia_v, ib_v, sa_v, sb_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ti[i] = sat(tdiv(t2_q[i], 16));
      ia_c[i] = '0;
      ib_c[i] = '0;
      sa_c[i] = '0;
      sb_c[i] = '0;
      case (f2_q.code)
        CASE_BOTH: begin
          ia_c[i] = ti[i];
          ib_c[i] = sat(-TW'($signed(ti[i])));
          sa_c[i] = sat(tdiv(TW'(sa2_q[i]), 8));
          sb_c[i] = sat(-tdiv(TW'(sb2_q[i]), 8));
        end
        CASE_A: begin
          ia_c[i] = ti[i];
          sa_c[i] = sat(tdiv(TW'(sa2_q[i]), 8));
        end
        CASE_B: begin
          ib_c[i] = ti[i];
          sb_c[i] = sat(tdiv(TW'(sa2_q[i]), 8));
        end
        default: begin
          ia_c[i] = '0;
        end
      endcase
    end
    ia_v = {ia_c[2], ia_c[1], ia_c[0]};
    ib_v = {ib_c[2], ib_c[1], ib_c[0]};
    sa_v = {sa_c[2], sa_c[1], sa_c[0]};
    sb_v = {sb_c[2], sb_c[1], sb_c[0]};
  end

  logic [PADW-1:0] ia_p, ib_p, sa_p, sb_p;
  assign ia_p = PADW'(ia_v);
  assign ib_p = PADW'(ib_v);
  assign sa_p = PADW'(sa_v);
  assign sb_p = PADW'(sb_v);

  logic [FIELD_W-1:0] ia_q, ib_q, sa_q, sb_q;
  logic [1:0]         code_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ia_q   <= ia_p[FIELD_W-1:0];
      ib_q   <= ib_p[FIELD_W-1:0];
      sa_q   <= sa_p[FIELD_W-1:0];
      sb_q   <= sb_p[FIELD_W-1:0];
      code_q <= f2_q.code;
    end
  end

  assign valid_o     = v3_q;
  assign impulse_a_o = ia_q;
  assign impulse_b_o = ib_q;
  assign shift_a_o   = sa_q;
  assign shift_b_o   = sb_q;
  assign case_code_o = code_q;

endmodule

`default_nettype wire

[rtl/impulse_collision_resolver.sv]
// Impulse collision resolver, one contact per beat.
// Input channel: valid_i / stall_o with the contact fields (velocities,
// normal, depth, inverse masses, restitutions, body kinds).
// Output channel: valid_o / stall_i with impulses, shifts and case_code_o.
// A beat moves when valid is high and stall is low.
// From input beat to output valid a contact passes five front stages
// (decode, products, dot sum, restitution multiply, range check),
// COMPONENT_WIDTH + 16 divider stages giving one quotient bit each, and
// three back stages ending in the output register.
// Throughput: one contact per cycle while the output is not stalled; the
// divider pipeline sets the depth.
// A stalled output freezes the whole pipeline; stall_o rises only while a
// result sits in the output register and stall_i is high, so no beat is
// lost or repeated.
// Reset clears all valid bits; no item is in flight afterwards and the
// block accepts at once.
`default_nettype none

module impulse_collision_resolver #(
  parameter int COMPONENT_WIDTH = icr_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic [icr_pkg::FIELD_W-1:0] velocity_a_i,
  input  wire logic [icr_pkg::FIELD_W-1:0] velocity_b_i,
  input  wire logic [icr_pkg::FIELD_W-1:0] contact_normal_i,
  input  wire logic [icr_pkg::DEPTH_W-1:0] penetration_depth_i,
  input  wire logic [icr_pkg::IMASS_W-1:0] inv_mass_a_i,
  input  wire logic [icr_pkg::IMASS_W-1:0] inv_mass_b_i,
  input  wire logic [icr_pkg::REST_W-1:0]  restitution_a_i,
  input  wire logic [icr_pkg::REST_W-1:0]  restitution_b_i,
  input  wire logic [1:0]                  kind_a_i,
  input  wire logic [1:0]                  kind_b_i,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic [icr_pkg::FIELD_W-1:0]      impulse_a_o,
  output logic [icr_pkg::FIELD_W-1:0]      impulse_b_o,
  output logic [icr_pkg::FIELD_W-1:0]      shift_a_o,
  output logic [icr_pkg::FIELD_W-1:0]      shift_b_o,
  output logic [1:0]                       case_code_o
);

  import icr_pkg::*;

  localparam int W   = COMPONENT_WIDTH;
  localparam int KW  = 2 * W + 15;
  localparam int JQ  = W + 16;
  localparam int NVW = 3 * (W + 1);
  localparam int FW  = $bits(flags_t);

  logic en;
  assign en      = !valid_o || !stall_i;
  assign stall_o = !en;

  logic               fr_valid;
  flags_t             fr_flags;
  logic [KW-1:0]      fr_kmag;
  logic [DEN_W-1:0]   fr_den;
  logic [NVW-1:0]     fr_n;
  logic [2*DEPTH_W-1:0] fr_num;
  logic [DEPTH_W-1:0] fr_depth;

  icr_front #(.W(W)) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .valid_i            (valid_i),
    .velocity_a_i       (velocity_a_i),
    .velocity_b_i       (velocity_b_i),
    .contact_normal_i   (contact_normal_i),
    .penetration_depth_i(penetration_depth_i),
    .inv_mass_a_i       (inv_mass_a_i),
    .inv_mass_b_i       (inv_mass_b_i),
    .restitution_a_i    (restitution_a_i),
    .restitution_b_i    (restitution_b_i),
    .kind_a_i           (kind_a_i),
    .kind_b_i           (kind_b_i),
    .valid_o            (fr_valid),
    .flags_o            (fr_flags),
    .kmag_o             (fr_kmag),
    .den_o              (fr_den),
    .n_o                (fr_n),
    .num_o              (fr_num),
    .depth_o            (fr_depth)
  );

  logic               dj_valid, ds_valid;
  logic [JQ-1:0]      dj_quot, ds_quot;
  logic [NVW+FW-1:0]  dj_side;
  logic [DEPTH_W-1:0] ds_side;
  flags_t             dj_flags;

  icr_div #(.DW(KW), .VW(DEN_W), .QW(JQ), .SW(NVW + FW)) u_div_j (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (fr_valid),
    .dividend_i(fr_kmag),
    .divisor_i (fr_den),
    .side_i    ({fr_n, fr_flags}),
    .valid_o   (dj_valid),
    .quot_o    (dj_quot),
    .side_o    (dj_side)
  );

  icr_div #(.DW(2 * DEPTH_W), .VW(DEN_W), .QW(JQ), .SW(DEPTH_W)) u_div_s (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (fr_valid),
    .dividend_i(fr_num),
    .divisor_i (fr_den),
    .side_i    (fr_depth),
    .valid_o   (ds_valid),
    .quot_o    (ds_quot),
    .side_o    (ds_side)
  );

  assign dj_flags = dj_side[FW-1:0];

  icr_back #(.W(W)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dj_valid),
    .quot_j_i   (dj_quot),
    .quot_s_i   (ds_quot),
    .n_i        (dj_side[NVW+FW-1:FW]),
    .flags_i    (dj_flags),
    .depth_i    (ds_side),
    .valid_o    (valid_o),
    .impulse_a_o(impulse_a_o),
    .impulse_b_o(impulse_b_o),
    .shift_a_o  (shift_a_o),
    .shift_b_o  (shift_b_o),
    .case_code_o(case_code_o)
  );

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dj_valid == ds_valid)
    else $error("divider lanes out of step");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && case_code_o == CASE_NONE |->
      impulse_a_o == '0 && impulse_b_o == '0 && shift_a_o == '0 && shift_b_o == '0)
    else $error("unresolved contact with nonzero result");

  a_only_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && case_code_o == CASE_A |-> impulse_b_o == '0 && shift_b_o == '0)
    else $error("second body moved in single body case");

  a_only_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && case_code_o == CASE_B |-> impulse_a_o == '0 && shift_a_o == '0)
    else $error("first body moved in single body case");

endmodule

`default_nettype wire
